// ----- hw/rtl/fraction_arith_reduce_unit_defines.svh -----
// Assertion macros for the port-level checker.
`ifndef FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
// Assert that a trigger implies a consequence in the same cycle.
`define FAR_ASSERT_IMPL(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);
// Assert that a trigger implies a consequence in the next cycle.
`define FAR_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/far_pkg.sv -----
// Package: types, constants and command structs for the fraction unit.
package far_pkg;
  localparam int OperandBits = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIV0   = 2'd1,
    ST_UNDEF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CHECK,
    S_GCD_START,
    S_GCD_RUN,
    S_QN_START,
    S_QN_RUN,
    S_QD_START,
    S_QD_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_start;
    logic [1:0] div_sel;  // 0: a mod b step, 1: num/g, 2: den/g
    logic gcd_swap;
    logic fin_zero;
    logic fin_norm;
    logic [1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic div0;
    logic b_zero;
    logic g_zero;
    logic div_busy;
  } stat_t;

  localparam logic [1:0] DivMod = 2'd0;
  localparam logic [1:0] DivNum = 2'd1;
  localparam logic [1:0] DivDen = 2'd2;
endpackage

// ----- hw/rtl/far_if.sv -----
// Valid/ready channel interface carrying one word of payload.
interface far_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/far_ctrl.sv -----
// Controller state machine: sequences multiply, GCD and division steps.
module far_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output far_pkg::cmd_t  cmd,
  input  far_pkg::stat_t stat
);
  import far_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_MUL;
      S_MUL:       state_next = S_SUM;
      S_SUM:       state_next = S_CHECK;
      S_CHECK: begin
        if (stat.div0) state_next = S_DONE;
        else state_next = S_GCD_START;
      end
      S_GCD_START: begin
        if (stat.b_zero) begin
          if (stat.g_zero) state_next = S_DONE;
          else state_next = S_QN_START;
        end else begin
          state_next = S_GCD_RUN;
        end
      end
      S_GCD_RUN:   if (!stat.div_busy) state_next = S_GCD_START;
      S_QN_START:  state_next = S_QN_RUN;
      S_QN_RUN:    if (!stat.div_busy) state_next = S_QD_START;
      S_QD_START:  state_next = S_QD_RUN;
      S_QD_RUN:    if (!stat.div_busy) state_next = S_DONE;
      S_DONE:      if (out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL: cmd.mul = 1'b1;
      S_SUM: cmd.sum = 1'b1;
      S_CHECK: begin
        if (stat.div0) begin
          cmd.fin_zero = 1'b1;
          cmd.fin_status = ST_DIV0;
        end
      end
      S_GCD_START: begin
        if (stat.b_zero) begin
          if (stat.g_zero) begin
            cmd.fin_zero = 1'b1;
            cmd.fin_status = ST_UNDEF;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DivMod;
        end
      end
      S_GCD_RUN: cmd.gcd_swap = !stat.div_busy;
      S_QN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DivNum;
      end
      S_QD_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DivDen;
      end
      S_QD_RUN: cmd.fin_norm = !stat.div_busy;
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/far_div.sv -----
// Restoring divider: one quotient bit per cycle.
module far_div #(
  parameter int W = 2 * far_pkg::OperandBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;

  assign trial = {rem[W-2:0], quot[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(W);
    end else if (busy) begin
      count <= count - CW'(1);
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hw/rtl/far_dp.sv -----
// Datapath: operand registers, products, GCD registers and result registers.
module far_dp #(
  parameter int OPERAND_BITS = far_pkg::OperandBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  req_type,
  input  logic signed [OPERAND_BITS-1:0] left_num,
  input  logic signed [OPERAND_BITS-1:0] left_den,
  input  logic signed [OPERAND_BITS-1:0] right_num,
  input  logic signed [OPERAND_BITS-1:0] right_den,
  input  far_pkg::cmd_t               cmd,
  output far_pkg::stat_t              stat,
  output logic signed [2*OPERAND_BITS:0]  out_num,
  output logic [2*OPERAND_BITS-2:0]   out_den,
  output logic [1:0]                  status
);
  import far_pkg::*;

  localparam int PW = 2 * OPERAND_BITS;
  localparam int NW = PW + 1;

  op_t                          op;
  logic signed [OPERAND_BITS-1:0] ln, ld, rn, rd;
  logic signed [PW-1:0]         p0, p1, pd;
  logic                         neg;
  logic [PW-1:0]                mag_n, mag_d, ga, gb;
  logic [PW-1:0]                dvd, dvs, quot, rem;
  logic                         busy;
  logic [NW-1:0]                num_w;
  logic [PW:0]                  den_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_t'(req_type);
      ln <= left_num;
      ld <= left_den;
      rn <= right_num;
      rd <= right_den;
    end
    if (cmd.mul) begin
      case (op)
        OP_MUL: begin
          p0 <= PW'(ln) * PW'(rn);
          p1 <= '0;
          pd <= PW'(ld) * PW'(rd);
        end
        OP_DIV: begin
          p0 <= PW'(ln) * PW'(rd);
          p1 <= '0;
          pd <= PW'(ld) * PW'(rn);
        end
        default: begin
          p0 <= PW'(ln) * PW'(rd);
          p1 <= PW'(rn) * PW'(ld);
          pd <= PW'(ld) * PW'(rd);
        end
      endcase
    end
  end

  assign num_w = (op == OP_SUB) ? (NW'(p0) - NW'(p1)) : (NW'(p0) + NW'(p1));
  assign den_w = {pd[PW-1], pd};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      neg <= num_w[NW-1] ^ pd[PW-1];
      mag_n <= num_w[NW-1] ? PW'(-num_w) : PW'(num_w);
      mag_d <= pd[PW-1] ? PW'(-den_w) : pd;
      ga <= num_w[NW-1] ? PW'(-num_w) : PW'(num_w);
      gb <= pd[PW-1] ? PW'(-den_w) : pd;
    end else if (cmd.gcd_swap) begin
      ga <= gb;
      gb <= rem;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DivNum:  begin dvd = mag_n; dvs = ga; end
      DivDen:  begin dvd = mag_d; dvs = ga; end
      default: begin dvd = ga;    dvs = gb; end
    endcase
  end

  far_div #(.W(PW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(dvd), .divisor(dvs), .busy(busy), .quot(quot), .rem(rem)
  );

  logic [PW-1:0] qn;

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DivDen) qn <= quot;
    if (cmd.fin_zero) begin
      out_num <= '0;
      out_den <= '0;
      status <= cmd.fin_status;
    end else if (cmd.fin_norm) begin
      out_num <= neg ? -NW'(qn) : NW'(qn);
      out_den <= quot[PW-2:0];
      status <= ST_OK;
    end
  end

  assign stat.div0 = (op == OP_DIV) && (rn == '0);
  assign stat.b_zero = (gb == '0);
  assign stat.g_zero = (ga == '0);
  assign stat.div_busy = busy;
endmodule

// ----- hw/rtl/fraction_arith_reduce_unit.sv -----
// Top level: fraction arithmetic with Euclidean GCD reduction.
// Usage:
//   Input channel "req" carries one word: req_type (0 add, 1 subtract,
//   2 multiply, 3 divide) and four signed operands left_num, left_den,
//   right_num, right_den. Output channel "rsp" carries out_num (signed),
//   out_den (never negative) and status (0 ok, 1 divide by a zero
//   fraction, 2 zero over zero).
//   One request is in flight at a time; req.ready is high only while idle.
//   After the accept the unit forms the products and the checks, then runs
//   each Euclid step in the shared bit-serial divider, makes a final GCD
//   check, then divides the numerator and the denominator by the GCD in
//   the same divider and presents the result on rsp.
//   The divider is restoring and yields one quotient bit per cycle while busy.
//   Divide by zero and zero over zero finish right after the checks.
//   Reset (rst, synchronous) returns the controller to idle and drops any
//   word in progress. While rsp.ready is low the result is held on rsp.
module fraction_arith_reduce_unit #(
  parameter int OPERAND_BITS = far_pkg::OperandBits
) (
  input logic clk,
  input logic rst,
  far_if.sink req,
  far_if.source rsp
);
  import far_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the word through the datapath.
  far_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  // Hold operands, products and the GCD state.
  far_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .req_type(req.data.req_type),
    .left_num(req.data.left_num), .left_den(req.data.left_den),
    .right_num(req.data.right_num), .right_den(req.data.right_den),
    .cmd(cmd), .stat(stat),
    .out_num(rsp.data.out_num), .out_den(rsp.data.out_den),
    .status(rsp.data.status)
  );
endmodule

// ----- hw/rtl/far_checker.sv -----
// Port-level checker for the fraction unit, bound to the top level.
`include "fraction_arith_reduce_unit_defines.svh"
module far_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status
);
  `FAR_ASSERT_IMPL(a_no_overlap, clk, rst, in_ready, !out_valid, "ready while result pending")
  `FAR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted twice")
  `FAR_ASSERT_IMPL(a_status_legal, clk, rst, out_valid, status != 2'd3, "bad status")
  `FAR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind fraction_arith_reduce_unit far_checker u_far_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .status(rsp.data.status)
);
